// File: hdl/clie_pkg.sv
// Shared constants for the circular list index engine.
// Field widths, request mode codes and result status codes.
package clie_pkg;

  // Fixed payload widths
  localparam int MODE_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 9;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request modes
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_APPEND = 2'd1;
  localparam mode_t MODE_POP    = 2'd2;

  // Result status codes
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

endpackage

// File: hdl/circular_list_index_engine_core.sv
// Circular list index engine: ordered circular list of signed 32-bit values.
// Depends on clie_pkg, clie_ram (value, link and free-slot stores) and clie_mod.
//
// A request is taken when the engine is idle and runs to completion before the
// next one is taken; the result sits in an output register, so a new word is
// accepted while the previous result waits. Insert at index and pop run through
// decode, the bit-serial remainder unit (index mod length), a link walk of that
// many hops through the next-link memory, link reads, slot allocation (insert
// only), link writes and the result handoff. Append skips the remainder unit and
// the walk, an insert into an empty list goes straight to slot allocation, and
// an error or unused-mode request goes straight to the handoff. A result held
// back by out_stall holds the following request in its last step. The list holds
// up to CAPACITY entries; freed slots are kept on a stack in memory and unused
// slots are handed out by a fill count, so no clearing pass follows reset.
module circular_list_index_engine_core #(
  parameter int CAPACITY = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [clie_pkg::MODE_W-1:0]     in_mode,
  input  logic signed [clie_pkg::VALUE_W-1:0] in_value,
  input  logic [clie_pkg::IDX_W-1:0]      in_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [clie_pkg::STATUS_W-1:0]   out_status,
  output logic signed [clie_pkg::VALUE_W-1:0] out_popped_value,
  output logic [clie_pkg::LEN_W-1:0]      out_length
);
  import clie_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_MOD     = 4'd2;
  localparam logic [3:0] S_WALK    = 4'd3;
  localparam logic [3:0] S_LINK_RD = 4'd4;
  localparam logic [3:0] S_LINK_Q  = 4'd5;
  localparam logic [3:0] S_ALLOC   = 4'd6;
  localparam logic [3:0] S_INS_W1  = 4'd7;
  localparam logic [3:0] S_INS_W2  = 4'd8;
  localparam logic [3:0] S_POP_W   = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]         state_r;
  mode_t              mode_r;
  logic [VALUE_W-1:0] value_r;
  logic [IDX_W-1:0]   index_r;
  status_t            status_r;
  logic [VALUE_W-1:0] popped_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      sp_r;
  logic [CW-1:0]      hw_r;
  logic [AW-1:0]      tgt_r;
  logic [AW-1:0]      cur_r;
  logic [AW-1:0]      steps_r;
  logic               primed_r;
  logic [AW-1:0]      p_r;
  logic [AW-1:0]      n_r;
  logic [AW-1:0]      slot_r;
  logic               empty_ins_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [VALUE_W-1:0] out_popped_r;
  logic [LEN_W-1:0]   out_length_r;

  logic               mod_start;
  logic               mod_done;
  logic [CW-1:0]      mod_rem;

  logic [AW-1:0]      cur_now;
  logic [CW-1:0]      sp_dec;
  logic [LEN_W+CW-1:0] len_ext;

  // Memory ports
  logic               val_we;
  logic [AW-1:0]      val_waddr;
  logic [VALUE_W-1:0] val_q;
  logic               nx_we;
  logic [AW-1:0]      nx_waddr;
  logic [AW-1:0]      nx_wdata;
  logic [AW-1:0]      nx_raddr;
  logic [AW-1:0]      nx_q;
  logic               pv_we;
  logic [AW-1:0]      pv_waddr;
  logic [AW-1:0]      pv_wdata;
  logic [AW-1:0]      pv_q;
  logic               fs_we;
  logic [AW-1:0]      fs_q;

  // Walk pointer: first hop from the latched slot, then straight from the link read
  assign cur_now  = primed_r ? nx_q : cur_r;
  assign sp_dec   = sp_r - 1'b1;
  assign len_ext  = {{LEN_W{1'b0}}, count_r};
  assign mod_start = (state_r == S_DECIDE);
  assign nx_raddr = (state_r == S_WALK) ? cur_now : tgt_r;

  // Link and value write selection
  always_comb begin
    val_we    = 1'b0;
    val_waddr = slot_r;
    nx_we     = 1'b0;
    nx_waddr  = slot_r;
    nx_wdata  = tgt_r;
    pv_we     = 1'b0;
    pv_waddr  = slot_r;
    pv_wdata  = p_r;
    fs_we     = 1'b0;
    case (state_r)
      S_INS_W1: begin
        val_we   = 1'b1;
        nx_we    = 1'b1;
        pv_we    = 1'b1;
        nx_wdata = empty_ins_r ? slot_r : tgt_r;
        pv_wdata = empty_ins_r ? slot_r : p_r;
      end
      S_INS_W2: begin
        nx_we    = 1'b1;
        nx_waddr = p_r;
        nx_wdata = slot_r;
        pv_we    = 1'b1;
        pv_waddr = tgt_r;
        pv_wdata = slot_r;
      end
      S_POP_W: begin
        nx_we    = 1'b1;
        nx_waddr = p_r;
        nx_wdata = n_r;
        pv_we    = 1'b1;
        pv_waddr = n_r;
        pv_wdata = p_r;
        fs_we    = 1'b1;
      end
      default: begin
        val_we = 1'b0;
      end
    endcase
  end

  clie_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (value_r),
    .raddr (tgt_r),
    .rdata (val_q)
  );

  clie_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_q)
  );

  clie_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (tgt_r),
    .rdata (pv_q)
  );

  // Stack of freed slots
  clie_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_free_ram (
    .clk   (clk),
    .we    (fs_we),
    .waddr (sp_r[AW-1:0]),
    .wdata (tgt_r),
    .raddr (sp_dec[AW-1:0]),
    .rdata (fs_q)
  );

  clie_mod #(.CW(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (index_r),
    .divisor  (count_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      sp_r        <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once it is taken, unless a new one loads now
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r      <= in_mode;
            value_r     <= in_value;
            index_r     <= in_index;
            status_r    <= STATUS_OK;
            popped_r    <= '0;
            empty_ins_r <= 1'b0;
            state_r     <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (mode_r == MODE_INSERT || mode_r == MODE_APPEND) begin
            if (count_r == CW'(CAPACITY)) begin
              status_r <= STATUS_FULL;
              state_r  <= S_DONE;
            end else if (count_r == '0) begin
              empty_ins_r <= 1'b1;
              state_r     <= S_ALLOC;
            end else if (mode_r == MODE_APPEND) begin
              tgt_r   <= head_r;
              state_r <= S_LINK_RD;
            end else begin
              state_r <= S_MOD;
            end
          end else if (mode_r == MODE_POP) begin
            if (count_r == '0) begin
              status_r <= STATUS_EMPTY;
              state_r  <= S_DONE;
            end else begin
              state_r <= S_MOD;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            steps_r  <= mod_rem[AW-1:0];
            cur_r    <= head_r;
            primed_r <= 1'b0;
            state_r  <= S_WALK;
          end
        end
        S_WALK: begin
          // Advance one link per cycle
          cur_r <= cur_now;
          if (steps_r == '0) begin
            tgt_r   <= cur_now;
            state_r <= S_LINK_RD;
          end else begin
            steps_r  <= steps_r - 1'b1;
            primed_r <= 1'b1;
          end
        end
        S_LINK_RD: begin
          state_r <= S_LINK_Q;
        end
        S_LINK_Q: begin
          p_r      <= pv_q;
          n_r      <= nx_q;
          if (mode_r == MODE_POP) begin
            popped_r <= val_q;
            state_r  <= S_POP_W;
          end else begin
            state_r <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          // Reuse a freed slot first, else take a fresh one
          if (sp_r != '0) begin
            slot_r <= fs_q;
            sp_r   <= sp_dec;
          end else begin
            slot_r <= hw_r[AW-1:0];
            hw_r   <= hw_r + 1'b1;
          end
          state_r <= S_INS_W1;
        end
        S_INS_W1: begin
          if (empty_ins_r) begin
            head_r  <= slot_r;
            count_r <= count_r + 1'b1;
            state_r <= S_DONE;
          end else begin
            state_r <= S_INS_W2;
          end
        end
        S_INS_W2: begin
          count_r <= count_r + 1'b1;
          state_r <= S_DONE;
        end
        S_POP_W: begin
          sp_r    <= sp_r + 1'b1;
          count_r <= count_r - 1'b1;
          head_r  <= (count_r == CW'(1)) ? '0 : n_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_popped_r <= popped_r;
            out_length_r <= len_ext[LEN_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_length       = out_length_r;

endmodule

// File: hdl/clie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the value, link and free-slot stores; no dependencies.
module clie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/clie_mod.sv
// Iterative remainder unit: index modulo list length, one quotient bit per cycle.
// Uses clie_pkg for the index width.
module clie_mod #(
  parameter int CW = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [clie_pkg::IDX_W-1:0] dividend,
  input  logic [CW-1:0]          divisor,
  output logic                   done,
  output logic [CW-1:0]          rem
);
  import clie_pkg::*;

  localparam int CNT_W = $clog2(IDX_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] dvd_r;
  logic [CW-1:0]    dvs_r;
  logic [CW-1:0]    rem_r;
  logic [CW:0]      shifted;
  logic [CW:0]      diff;
  logic             fits;

  // Shared compare-subtract step
  assign shifted = {rem_r, dvd_r[IDX_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  // Sequence one bit per cycle, most significant first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(IDX_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[IDX_W-2:0], 1'b0};
      rem_r <= fits ? diff[CW-1:0] : shifted[CW-1:0];
    end
  end

  assign done = !busy_r;
  assign rem  = rem_r;

endmodule

// File: tb/circular_list_index_engine_core_test.sv
// Self-checking testbench for the circular list index engine.
// Depends on clie_pkg and circular_list_index_engine_core; the expected list is
// kept as an ordered queue of values, head first.
`timescale 1ns / 1ps

module circular_list_index_engine_core_test;
  import clie_pkg::*;

  localparam int LIST_CAPACITY = 256;
  localparam int CLK_HALF_NS = 10;
  localparam mode_t MODE_UNUSED = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [IDX_W-1:0]          idx_t;

  typedef struct {
    status_t    status;
    value_t     popped;
    logic [LEN_W-1:0] length;
  } list_result_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  mode_t  in_mode = MODE_INSERT;
  value_t in_value = '0;
  idx_t   in_index = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  status_t out_status;
  value_t out_popped_value;
  logic [LEN_W-1:0] out_length;

  // Expected list contents, head first, and results still owed by the block
  value_t       list_model[$];
  list_result_t awaited_results[$];

  bit idle_on = 1'b0;
  int long_hold_cycles = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int n_insert = 0, n_append = 0, n_pop = 0, n_unused = 0;
  int n_full = 0, n_empty = 0, peak_length = 0;

  circular_list_index_engine_core #(
    .CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_value(in_value),
    .in_index(in_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_popped_value(out_popped_value),
    .out_length(out_length)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Apply one accepted request to the list and queue the result it must give
  function automatic void predict_list_result(input mode_t mode, input value_t value,
                                              input idx_t index);
    list_result_t res;
    int len;
    int pos;
    value_t moved;
    len = list_model.size();
    res.status = STATUS_OK;
    res.popped = '0;
    case (mode)
      MODE_INSERT, MODE_APPEND: begin
        if (mode == MODE_INSERT) n_insert++;
        else n_append++;
        if (len >= LIST_CAPACITY) begin
          res.status = STATUS_FULL;
          n_full++;
        end else if (mode == MODE_INSERT && len > 0 && (int'(index) % len) != 0) begin
          // land before the element at that position; head stays put
          list_model.insert(int'(index) % len, value);
        end else begin
          // before the head is the tail end of the circle
          list_model = {list_model, value};
        end
      end
      MODE_POP: begin
        n_pop++;
        if (len == 0) begin
          res.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          pos = int'(index) % len;
          res.popped = list_model[pos];
          list_model.delete(pos);
          // successor of the removed element becomes the head
          repeat (pos) begin
            moved = list_model.pop_front();
            list_model = {list_model, moved};
          end
        end
      end
      default: n_unused++;
    endcase
    res.length = LEN_W'(list_model.size());
    if (list_model.size() > peak_length) peak_length = list_model.size();
    awaited_results = {awaited_results, res};
  endfunction

  // Offer one word and hold it until the block takes it
  task automatic send_word(input mode_t mode, input value_t value, input idx_t index);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    in_index <= index;
    do @(posedge clk); while (in_stall);
    predict_list_result(mode, value, index);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic idx_t pick_index(input int len);
    case ($urandom_range(0, 5))
      0, 1: return idx_t'($urandom_range(0, 65535));
      2: return '0;
      3: return '1;
      default: return idx_t'($urandom_range(0, (len > 0) ? 2 * len : 4));
    endcase
  endfunction

  // Compare each result the block hands over with the oldest one owed
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with none owed: status %0d popped %0d length %0d",
                                  out_status, out_popped_value, out_length));
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d status got %0d want %0d",
                                    results_seen, out_status, want.status));
        if (out_popped_value !== want.popped)
          report_mismatch($sformatf("result %0d popped_value got %0d want %0d",
                                    results_seen, out_popped_value, want.popped));
        if (out_length !== want.length)
          report_mismatch($sformatf("result %0d length got %0d want %0d",
                                    results_seen, out_length, want.length));
      end
    end
  end

  // Receiver side: random stall bursts, or one long counted hold-off on request
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        n = long_hold_cycles;
        long_hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Empty-list errors, extremes of every field, index wrap, last-entry pop
  task automatic test_directed();
    send_word(MODE_POP, 32'sh1234_5678, '0);
    send_word(MODE_UNUSED, '1, '1);
    send_word(MODE_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
    send_word(MODE_APPEND, 32'sh8000_0000, 16'h5555);
    send_word(MODE_INSERT, '0, '0);
    send_word(MODE_INSERT, '1, 16'd1);
    send_word(MODE_INSERT, 32'sh0000_0001, 16'hFFFF);
    send_word(MODE_INSERT, 32'sh5555_5555, 16'h8000);
    send_word(MODE_INSERT, 32'shAAAA_AAAA, 16'h2AAA);
    send_word(MODE_UNUSED, 32'sh5555_5555, '0);
    send_word(MODE_POP, '0, 16'hFFFF);
    send_word(MODE_POP, '1, '0);
    send_word(MODE_POP, '0, 16'd2);
    send_word(MODE_APPEND, 32'shAAAA_AAAA, '0);
    // empty it out, then reuse the list from scratch
    while (list_model.size() > 0)
      send_word(MODE_POP, '0, idx_t'($urandom_range(0, 65535)));
    send_word(MODE_POP, '0, 16'd7);
    send_word(MODE_APPEND, 32'sh0000_00FF, '0);
    send_word(MODE_INSERT, 32'shFFFF_FF00, 16'd1);
    send_word(MODE_POP, '0, 16'd1);
  endtask

  // Fill to capacity, hit the full case with insert and append, then trim
  task automatic test_fill_to_capacity();
    while (list_model.size() < LIST_CAPACITY) begin
      if ($urandom_range(0, 3) == 0)
        send_word(MODE_INSERT, pick_value(), pick_index(list_model.size()));
      else
        send_word(MODE_APPEND, pick_value(), pick_index(list_model.size()));
    end
    send_word(MODE_INSERT, 32'sh7FFF_FFFF, 16'd3);
    send_word(MODE_APPEND, 32'sh8000_0000, '0);
    send_word(MODE_UNUSED, '0, '0);
    send_word(MODE_POP, '0, 16'hFFFF);
    send_word(MODE_INSERT, 32'sh0BAD_F00D, 16'd255);
    send_word(MODE_APPEND, '1, '0);
    repeat (40) send_word(MODE_POP, '0, pick_index(list_model.size()));
  endtask

  // Hold the receiver off long enough that the block backs up its input
  task automatic test_receiver_hold_off();
    idle_on = 1'b0;
    long_hold_cycles = 600;
    repeat (12) begin
      if ($urandom_range(0, 1) == 0)
        send_word(MODE_APPEND, pick_value(), '0);
      else
        send_word(MODE_UNUSED, pick_value(), pick_index(list_model.size()));
    end
    idle_on = 1'b1;
  endtask

  // Random requests that steer the length toward a moving target
  task automatic test_random_walk(input int count);
    int target;
    int len;
    int grow_pct;
    int r;
    mode_t mode;
    target = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 0) begin
        case ($urandom_range(0, 4))
          0: target = 0;
          1: target = LIST_CAPACITY;
          default: target = $urandom_range(1, LIST_CAPACITY - 1);
        endcase
      end
      len = list_model.size();
      grow_pct = (len < target) ? 85 : (len > target) ? 12 : 50;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3)
        mode = MODE_UNUSED;
      else if (r < grow_pct)
        mode = ($urandom_range(0, 2) == 0) ? MODE_APPEND : MODE_INSERT;
      else
        mode = MODE_POP;
      send_word(mode, pick_value(), pick_index(len));
    end
  endtask

  initial begin : run_tests
    int waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    test_directed();
    test_fill_to_capacity();
    test_receiver_hold_off();
    test_random_walk(600);
    // last stretch runs with no idling on either side
    idle_on = 1'b0;
    test_random_walk(60);
    @(posedge clk);
    in_valid <= 1'b0;

    // drain what is still owed, then watch for stray results
    waited = 0;
    while (awaited_results.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (awaited_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

    $display("Covered %0d inserts, %0d appends, %0d pops, %0d unused-mode requests.",
             n_insert, n_append, n_pop, n_unused);
    $display("Peak length %0d, %0d rejected as full, %0d pops on empty, %0d mismatches.",
             peak_length, n_full, n_empty, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog well past the slowest legal run
  initial begin : watchdog
    #(64'd1_500_000 * 2 * CLK_HALF_NS);
    $display("Timed out with %0d results owed.", awaited_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
